>>> design/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the stable min priority queue
// Holds the heap geometry, the entry record, the controller interface and the ordering function.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned Depth    = 64;
  localparam int unsigned SeqWidth = 32;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned PayW     = 20;
  localparam int unsigned EntW     = 8 + PayW + SeqWidth;

  localparam logic       CmdInsert = 1'b0;
  localparam logic       CmdPop    = 1'b1;
  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StEmpty   = 2'd2;

  typedef struct packed {
    logic [7:0]          prio;
    logic [PayW-1:0]     pay;
    logic [SeqWidth-1:0] seq;
  } entry_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;      // capture request, start operation
    logic rd_a;      // read parent (insert) or both children (pop)
    logic step;      // evaluate one level, write swaps
    logic finish;    // write sifted entry to its final slot
  } dp_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic quick;     // operation needs no heap walk
    logic done;      // walk finished at this level
  } dp_sts_t;

  function automatic logic before_f(entry_t a, entry_t b);
    if (a.prio != b.prio) begin
      return a.prio < b.prio;
    end
    return a.seq < b.seq;
  endfunction

endpackage

>>> design/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl: operation sequencer
// Steps one request through load, per-level read and compare, and result.
// ----------------------------------------------------------------------------
module smpq_ctrl import smpq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SRead = 5'b00010,
    SStep = 5'b00100,
    SFin  = 5'b01000,
    SOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == SIdle);
  assign res_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SRead;
        end
      end
      SRead: begin
        if (sts_i.quick) begin
          state_d = SFin;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = SStep;
        end
      end
      SStep: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.done ? SFin : SRead;
      end
      SFin: begin
        cmd_o.finish = 1'b1;
        state_d      = SOut;
      end
      SOut: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result dropped");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == SRead)
    else $error("load did not start walk");

endmodule

>>> design/smpq_dp.sv
// ----------------------------------------------------------------------------
// smpq_dp: heap storage and one-level sift datapath
// Holds the heap memory, count, sequence counter and the result register.
// ----------------------------------------------------------------------------
module smpq_dp import smpq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_cmd_i,
  input  logic [7:0]    in_prio_i,
  input  logic [PayW-1:0] in_pay_i,
  input  dp_cmd_t       cmd_i,
  output dp_sts_t       sts_o,
  output logic [1:0]    status_o,
  output logic [7:0]    out_prio_o,
  output logic [PayW-1:0] out_pay_o,
  output logic [CntW-1:0] occ_o
);

  // The memory has one write port and two read ports (the parent, or the
  // two children); the current node is held in a register.
  entry_t mem [Depth];

  logic [CntW-1:0]     count_q;
  logic [SeqWidth-1:0] seq_q;
  logic                op_q;
  logic                quick_q;
  logic [1:0]          status_q;
  entry_t              cur_q;       // entry being sifted
  logic [AddrW-1:0]    pos_q;
  entry_t              ra_q, rb_q;  // registered reads
  logic [CntW-1:0]     pos_w;
  logic [CntW:0]       lft_w;
  logic [CntW-1:0]     par_w;
  logic                l_ok, r_ok, done_w;
  logic                pick_r;
  entry_t              best;

  assign pos_w = CntW'(pos_q);
  assign lft_w = {pos_w, 1'b1};
  assign par_w = (pos_w - CntW'(1)) >> 1;
  assign l_ok  = lft_w < (CntW+1)'(count_q);
  assign r_ok  = (lft_w + (CntW+1)'(1)) < (CntW+1)'(count_q);
  assign pick_r = r_ok && before_f(rb_q, ra_q);
  assign best  = pick_r ? rb_q : ra_q;

  always_comb begin
    if (op_q == CmdInsert) begin
      done_w = (pos_q == '0) || !before_f(cur_q, ra_q);
    end else begin
      done_w = !l_ok || !before_f(best, cur_q);
    end
  end

  assign sts_o.quick = quick_q || (op_q == CmdInsert ? pos_q == '0 : !l_ok);
  assign sts_o.done  = done_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_a) begin
      if (op_q == CmdInsert) begin
        ra_q <= mem[par_w[AddrW-1:0]];
      end else begin
        ra_q <= mem[lft_w[AddrW-1:0]];
        rb_q <= mem[AddrW'(lft_w + (CntW+1)'(1))];
      end
    end
    if (cmd_i.load && in_cmd_i == CmdPop && count_q != '0) begin
      cur_q <= mem[AddrW'(count_q - CntW'(1))];
      {out_prio_o, out_pay_o} <= {mem[0].prio, mem[0].pay};
    end else if (cmd_i.load) begin
      cur_q <= '{prio: in_prio_i, pay: in_pay_i, seq: seq_q};
      {out_prio_o, out_pay_o} <= '0;
    end
    if (cmd_i.step && !done_w) begin
      if (op_q == CmdInsert) begin
        mem[pos_q] <= ra_q;
        pos_q      <= par_w[AddrW-1:0];
      end else begin
        mem[pos_q] <= best;
        pos_q      <= pick_r ? AddrW'(lft_w + (CntW+1)'(1)) : lft_w[AddrW-1:0];
      end
    end
    if (cmd_i.load) begin
      pos_q <= (in_cmd_i == CmdInsert) ? AddrW'(count_q) : '0;
    end
    if (cmd_i.finish && !quick_q) begin
      mem[pos_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      seq_q    <= '0;
      op_q     <= CmdInsert;
      quick_q  <= 1'b0;
      status_q <= StDone;
    end else if (cmd_i.load) begin
      op_q <= in_cmd_i;
      if (in_cmd_i == CmdInsert) begin
        if (count_q >= CntW'(Depth)) begin
          quick_q  <= 1'b1;
          status_q <= StFull;
        end else begin
          quick_q  <= 1'b0;
          status_q <= StDone;
          count_q  <= count_q + CntW'(1);
          seq_q    <= seq_q + SeqWidth'(1);
        end
      end else begin
        if (count_q == '0) begin
          quick_q  <= 1'b1;
          status_q <= StEmpty;
        end else begin
          quick_q  <= 1'b0;
          status_q <= StDone;
          count_q  <= count_q - CntW'(1);
        end
      end
    end
  end

  assign status_o = status_q;
  assign occ_o    = count_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("count overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && in_cmd_i == CmdInsert && count_q == CntW'(Depth) |=> $stable(count_q))
    else $error("full insert changed count");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == StEmpty |-> quick_q)
    else $error("empty pop walked heap");

endmodule

>>> design/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue: bounded stable min-heap of process entries
// Top level joining the sequencer and the heap datapath.
// ----------------------------------------------------------------------------
// Each request on the slave stream is an insert (tuser = 0) or a pop
// (tuser = 1). An insert stores priority, process id and state tag, stamped
// with a running sequence number so equal priorities leave in arrival order.
// A pop returns the smallest entry. Exactly one response follows every request
// on the master stream, carrying status, the popped entry (zeros otherwise)
// and the occupancy after the operation.
// One request is handled at a time. Each level of the heap walk is a memory
// read, then a compare and swap. When no walk is needed the response is
// offered after the read and finish states; otherwise it follows the walked
// levels and the finish state. s_axis_tready is high again right after the
// edge that takes the response.
// While the receiver stalls, the response is held and no request is accepted.
// Reset empties the queue and clears the sequence counter; the heap memory
// itself is not cleared.
// ----------------------------------------------------------------------------
module stable_min_priority_queue import smpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // priority_req[7:0], proc_id[23:8], proc_state[27:24]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status[1:0], out_priority[9:2], out_pid[25:10],
                                      // out_state[29:26], occupancy[36:30]
);

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [1:0]      status;
  logic [7:0]      oprio;
  logic [PayW-1:0] opay;
  logic [CntW-1:0] occ;

  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Payload keeps process id above the state tag.
  smpq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_cmd_i   (s_axis_tuser),
    .in_prio_i  (s_axis_tdata[7:0]),
    .in_pay_i   ({s_axis_tdata[23:8], s_axis_tdata[27:24]}),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .status_o   (status),
    .out_prio_o (oprio),
    .out_pay_o  (opay),
    .occ_o      (occ)
  );

  assign m_axis_tdata = {3'b000, 7'(occ), opay[3:0], opay[19:4], oprio, status};

endmodule
